[sv/tgen_pkg.sv]
// Shared types and constants for the triangle tangent generator.
package tgen_pkg;

  // Vertex map size and derived widths
  localparam int MAX_VERTICES = 4096;
  localparam int MAP_AW       = $clog2(MAX_VERTICES);
  localparam int EPOCH_W      = 8;

  // Field widths
  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int UV_W  = 16;
  localparam int TAN_W = 16;

  // Internal arithmetic widths
  localparam int EDGE_W  = POS_W + 1;
  localparam int DUV_W   = UV_W + 1;
  localparam int DET_W   = 2 * DUV_W + 1;
  localparam int CV_W    = 52;
  localparam int MAG_W   = 51;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NMAG_W  = 30;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = 63;
  localparam int LEN_W   = 31;
  localparam int ONE_SH  = 14;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = NMAG_W + ONE_SH + 1;

  // Normalization window for the largest component
  localparam logic [MAG_W-1:0] NORM_HI = MAG_W'(64'd1 << 30);
  localparam logic [MAG_W-1:0] NORM_LO = MAG_W'(64'd1 << 29);
  localparam logic [ROOT_W-1:0] ROOT_TOP = ROOT_W'(64'd1 << 62);

  // Configuration register map
  localparam int APB_AW = 2;
  localparam logic [APB_AW-1:0] REG_QUAD_MODE = '0;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [UV_W-1:0]  u;
    logic signed [UV_W-1:0]  v;
  } corner_t;

  typedef struct packed {
    logic start;
  } calc_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic                    deg;
    logic signed [TAN_W-1:0] tx;
    logic signed [TAN_W-1:0] ty;
    logic signed [TAN_W-1:0] tz;
  } calc_rsp_t;

endpackage

[sv/triangle_tangent_generator.sv]
// Top level: corner buffer, seen-vertex map, result sequencing and configuration port.
// Corners are taken one per transaction. A corner that does not close a primitive is only
// buffered. The corner that closes a primitive starts the tangent engine, which runs one
// shared multiplier (eight products, then three squares), a one-bit-per-cycle normalizing shift,
// a 32-step square root and three divides, and stops early with a degenerate result when the UV
// determinant is zero. In triangle mode the seen-vertex map is then checked for each of the three
// corners. Results then leave one per cycle as the output side takes them; the next corner is
// taken while the last result still waits. The seen map is cleared by a pass over all
// MAX_VERTICES entries (4096) after reset, and again on every 255th mesh start, during which
// no corner is taken; otherwise a mesh start only advances an epoch mark. A write to
// quad_mode drops a partly buffered primitive.
module triangle_tangent_generator (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tgen_pkg::APB_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // corner input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mesh_start,
  input  logic [tgen_pkg::IDX_W-1:0]         vertex_index,
  input  logic signed [tgen_pkg::POS_W-1:0]  pos_x,
  input  logic signed [tgen_pkg::POS_W-1:0]  pos_y,
  input  logic signed [tgen_pkg::POS_W-1:0]  pos_z,
  input  logic signed [tgen_pkg::UV_W-1:0]   tex_u,
  input  logic signed [tgen_pkg::UV_W-1:0]   tex_v,
  // tangent output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tgen_pkg::TAN_W-1:0]  tan_x,
  output logic signed [tgen_pkg::TAN_W-1:0]  tan_y,
  output logic signed [tgen_pkg::TAN_W-1:0]  tan_z,
  output logic [tgen_pkg::IDX_W-1:0]         corner_vertex,
  output logic                               degenerate,
  output logic                               last_of_primitive
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b00_0001,
    S_IDLE  = 6'b00_0010,
    S_CALC  = 6'b00_0100,
    S_LOOK  = 6'b00_1000,
    S_CHECK = 6'b01_0000,
    S_EMIT  = 6'b10_0000
  } state_t;

  state_t                          state;
  logic                            quad_mode;
  logic [1:0]                      count;
  tgen_pkg::corner_t               corners [4];
  logic [tgen_pkg::EPOCH_W-1:0]    epoch;
  logic [tgen_pkg::MAP_AW-1:0]     clr_addr;
  logic [3:0]                      mask;
  logic [1:0]                      kc;
  tgen_pkg::calc_req_t             req;
  tgen_pkg::calc_rsp_t             rsp;

  // Configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == tgen_pkg::REG_QUAD_MODE);
  assign prdata = (paddr == tgen_pkg::REG_QUAD_MODE) ? {31'd0, quad_mode} : 32'd0;

  assign in_ready = (state == S_IDLE);

  // Tangent engine
  tgen_calc u_calc (
    .clk (clk),
    .rst (rst),
    .req (req),
    .c0  (corners[0]),
    .c1  (corners[1]),
    .c2  (corners[2]),
    .rsp (rsp)
  );

  // Seen-vertex map: one epoch tag per vertex
  logic [tgen_pkg::IDX_W-1:0]   cur_idx;
  logic [tgen_pkg::MAP_AW-1:0]  map_addr;
  logic                         in_range, seen;
  logic                         map_we;
  logic [tgen_pkg::MAP_AW-1:0]  map_waddr;
  logic [tgen_pkg::EPOCH_W-1:0] map_wdata, map_rdata;

  assign cur_idx  = corners[kc].idx;
  assign map_addr = tgen_pkg::MAP_AW'(cur_idx);
  assign in_range = (32'(cur_idx) < 32'(tgen_pkg::MAX_VERTICES));
  assign seen     = in_range && (map_rdata == epoch);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = map_addr;
    map_wdata = epoch;
    if (state == S_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_addr;
      map_wdata = '0;
    end else if (state == S_CHECK) begin
      map_we = in_range && !seen;
    end
  end

  tgen_ram #(
    .WIDTH (tgen_pkg::EPOCH_W),
    .DEPTH (tgen_pkg::MAX_VERTICES)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_addr),
    .rdata (map_rdata)
  );

  // Lowest pending corner in the emit mask
  logic [1:0] sel;
  logic [3:0] rest;
  always_comb begin
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (mask[i]) sel = 2'(i);
    end
    rest = mask & ~(4'b0001 << sel);
  end

  // Corner slot for an accepted transaction
  logic [1:0] slot;
  logic       closes;
  assign slot   = mesh_start ? 2'd0 : count;
  assign closes = quad_mode ? (slot == 2'd3) : (slot == 2'd2);

  logic emit_load;
  assign emit_load = (state == S_EMIT) && (mask != 4'd0) && (!out_valid || out_ready);

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      epoch     <= '0;
      quad_mode <= 1'b0;
      count     <= '0;
      req.start <= 1'b0;
      kc        <= '0;
      mask      <= '0;
    end else begin
      req.start <= 1'b0;
      if (cfg_we) begin
        quad_mode <= pwdata[0];
        count     <= '0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == tgen_pkg::MAP_AW'(tgen_pkg::MAX_VERTICES - 1)) begin
            clr_addr <= '0;
            epoch    <= tgen_pkg::EPOCH_W'(1);
            state    <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            corners[slot] <= '{idx: vertex_index, px: pos_x, py: pos_y, pz: pos_z,
                               u: tex_u, v: tex_v};
            if (mesh_start) begin
              if (epoch == '1) state <= S_CLEAR;
              else             epoch <= epoch + 1'b1;
            end
            if (closes) begin
              count     <= '0;
              req.start <= 1'b1;
              state     <= S_CALC;
            end else begin
              count <= slot + 2'd1;
            end
          end
        end
        S_CALC: begin
          if (rsp.done) begin
            kc <= '0;
            if (quad_mode) begin
              mask  <= 4'b1111;
              state <= S_EMIT;
            end else begin
              mask  <= '0;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_CHECK;
        S_CHECK: begin
          mask[kc] <= !seen;
          if (kc == 2'd2) begin
            state <= S_EMIT;
          end else begin
            kc    <= kc + 2'd1;
            state <= S_LOOK;
          end
        end
        S_EMIT: begin
          if (mask == 4'd0) begin
            state <= S_IDLE;
          end else if (emit_load) begin
            mask <= rest;
            if (rest == 4'd0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      tan_x             <= rsp.tx;
      tan_y             <= rsp.ty;
      tan_z             <= rsp.tz;
      corner_vertex     <= corners[sel].idx;
      degenerate        <= rsp.deg;
      last_of_primitive <= (rest == 4'd0);
    end
  end

`ifndef SYNTHESIS
  // Triangle mode never holds three buffered corners
  a_tri_count: assert property (@(posedge clk) disable iff (rst)
    !quad_mode |-> (count != 2'd3))
    else $error("corner count out of range in triangle mode");

  // Results go out only once the engine has finished
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !rsp.busy)
    else $error("emit while tangent engine busy");

  // A degenerate result carries a zero tangent
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (tan_x == '0 && tan_y == '0 && tan_z == '0))
    else $error("degenerate result with nonzero tangent");
`endif

endmodule

[sv/tgen_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tgen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tgen_calc.sv]
// Tangent engine: one shared multiplier plus iterative normalize, square root and divide.
module tgen_calc (
  input  logic                clk,
  input  logic                rst,
  input  tgen_pkg::calc_req_t req,
  input  tgen_pkg::corner_t   c0,
  input  tgen_pkg::corner_t   c1,
  input  tgen_pkg::corner_t   c2,
  output tgen_pkg::calc_rsp_t rsp
);

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_MUL  = 8'b0000_0010,
    M_SIGN = 8'b0000_0100,
    M_NORM = 8'b0000_1000,
    M_SQ   = 8'b0001_0000,
    M_SQRT = 8'b0010_0000,
    M_DIV  = 8'b0100_0000,
    M_DONE = 8'b1000_0000
  } mstate_t;

  mstate_t state;
  logic [4:0] cnt;
  logic [1:0] kc;

  logic signed [tgen_pkg::EDGE_W-1:0] e1 [3];
  logic signed [tgen_pkg::EDGE_W-1:0] e2 [3];
  logic signed [tgen_pkg::DUV_W-1:0]  du1, dv1, du2, dv2;
  logic signed [tgen_pkg::DET_W-1:0]  det;
  logic signed [tgen_pkg::CV_W-1:0]   cv [3];
  logic [tgen_pkg::MAG_W-1:0]         mag [3];
  logic [2:0]                         neg;
  logic [tgen_pkg::SUM_W-1:0]         sum;
  logic [tgen_pkg::ROOT_W-1:0]        rx, rr, rbit;
  logic [tgen_pkg::LEN_W:0]           rem;
  logic [tgen_pkg::QUO_W-1:0]         numlo, quo;
  logic                               deg;
  logic signed [tgen_pkg::TAN_W-1:0]  tan [3];

  // Shared multiplier, registered output
  logic signed [tgen_pkg::MUL_W-1:0]  ma, mb;
  logic signed [tgen_pkg::PROD_W-1:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == M_MUL) begin
      case (cnt)
        5'd0: begin ma = tgen_pkg::MUL_W'(du1);   mb = tgen_pkg::MUL_W'(dv2); end
        5'd1: begin ma = tgen_pkg::MUL_W'(du2);   mb = tgen_pkg::MUL_W'(dv1); end
        5'd2: begin ma = e1[0]; mb = tgen_pkg::MUL_W'(dv2); end
        5'd3: begin ma = e2[0]; mb = tgen_pkg::MUL_W'(dv1); end
        5'd4: begin ma = e1[1]; mb = tgen_pkg::MUL_W'(dv2); end
        5'd5: begin ma = e2[1]; mb = tgen_pkg::MUL_W'(dv1); end
        5'd6: begin ma = e1[2]; mb = tgen_pkg::MUL_W'(dv2); end
        5'd7: begin ma = e2[2]; mb = tgen_pkg::MUL_W'(dv1); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state == M_SQ && cnt < 5'd3) begin
      ma = $signed({3'b000, mag[cnt[1:0]][tgen_pkg::NMAG_W-1:0]});
      mb = ma;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Largest magnitude for normalization
  logic [tgen_pkg::MAG_W-1:0] mx;
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  // Square root step
  logic [tgen_pkg::ROOT_W-1:0] rsum;
  logic [tgen_pkg::SUM_W-1:0]  sum_add;
  assign rsum    = rr + rbit;
  assign sum_add = sum + prod[tgen_pkg::SUM_W-1:0];

  // Division step
  logic [tgen_pkg::LEN_W-1:0] len;
  logic [tgen_pkg::NUM_W-1:0] num;
  logic [tgen_pkg::LEN_W:0]   trial;
  logic                       qbit;
  logic [tgen_pkg::QUO_W-1:0] qfin;
  assign len   = rr[tgen_pkg::LEN_W-1:0];
  assign num   = tgen_pkg::NUM_W'({mag[kc][tgen_pkg::NMAG_W-1:0], {tgen_pkg::ONE_SH{1'b0}}})
               + tgen_pkg::NUM_W'(len >> 1);
  assign trial = {rem[tgen_pkg::LEN_W-1:0], numlo[tgen_pkg::QUO_W-1]};
  assign qbit  = (trial >= {1'b0, len});
  assign qfin  = {quo[tgen_pkg::QUO_W-2:0], qbit};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
      kc    <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.start) begin
            e1[0] <= $signed({c1.px[31], c1.px}) - $signed({c0.px[31], c0.px});
            e1[1] <= $signed({c1.py[31], c1.py}) - $signed({c0.py[31], c0.py});
            e1[2] <= $signed({c1.pz[31], c1.pz}) - $signed({c0.pz[31], c0.pz});
            e2[0] <= $signed({c2.px[31], c2.px}) - $signed({c0.px[31], c0.px});
            e2[1] <= $signed({c2.py[31], c2.py}) - $signed({c0.py[31], c0.py});
            e2[2] <= $signed({c2.pz[31], c2.pz}) - $signed({c0.pz[31], c0.pz});
            du1   <= $signed({c1.u[15], c1.u}) - $signed({c0.u[15], c0.u});
            dv1   <= $signed({c1.v[15], c1.v}) - $signed({c0.v[15], c0.v});
            du2   <= $signed({c2.u[15], c2.u}) - $signed({c0.u[15], c0.u});
            dv2   <= $signed({c2.v[15], c2.v}) - $signed({c0.v[15], c0.v});
            deg   <= 1'b0;
            tan[0] <= '0;
            tan[1] <= '0;
            tan[2] <= '0;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          // product of step cnt-1 lands now
          case (cnt)
            5'd1: det   <= $signed(prod[tgen_pkg::DET_W-1:0]);
            5'd2: det   <= det - $signed(prod[tgen_pkg::DET_W-1:0]);
            5'd3: cv[0] <= $signed(prod[tgen_pkg::CV_W-1:0]);
            5'd4: cv[0] <= cv[0] - $signed(prod[tgen_pkg::CV_W-1:0]);
            5'd5: cv[1] <= $signed(prod[tgen_pkg::CV_W-1:0]);
            5'd6: cv[1] <= cv[1] - $signed(prod[tgen_pkg::CV_W-1:0]);
            5'd7: cv[2] <= $signed(prod[tgen_pkg::CV_W-1:0]);
            5'd8: cv[2] <= cv[2] - $signed(prod[tgen_pkg::CV_W-1:0]);
            default: ;
          endcase
          cnt <= cnt + 5'd1;
          if (cnt == 5'd8) state <= M_SIGN;
        end
        M_SIGN: begin
          if (det == '0) begin
            deg   <= 1'b1;
            state <= M_DONE;
          end else begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= cv[k][tgen_pkg::CV_W-1] ? tgen_pkg::MAG_W'(-cv[k])
                                               : tgen_pkg::MAG_W'(cv[k]);
              neg[k] <= det[tgen_pkg::DET_W-1] ? (cv[k] > 0) : (cv[k] < 0);
            end
            state <= M_NORM;
          end
        end
        M_NORM: begin
          if (mx == '0) begin
            deg   <= 1'b1;
            state <= M_DONE;
          end else if (mx >= tgen_pkg::NORM_HI) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (mx < tgen_pkg::NORM_LO) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            sum   <= '0;
            cnt   <= '0;
            state <= M_SQ;
          end
        end
        M_SQ: begin
          if (cnt != 5'd0) sum <= sum_add;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            rx    <= tgen_pkg::ROOT_W'(sum_add);
            rr    <= '0;
            rbit  <= tgen_pkg::ROOT_TOP;
            state <= M_SQRT;
          end
        end
        M_SQRT: begin
          if (rx >= rsum) begin
            rx <= rx - rsum;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit == tgen_pkg::ROOT_W'(1)) begin
            cnt   <= '0;
            kc    <= '0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          if (cnt == 5'd0) begin
            if (len == '0) begin
              deg   <= 1'b1;
              state <= M_DONE;
            end else begin
              rem   <= (tgen_pkg::LEN_W + 1)'(num[tgen_pkg::NUM_W-1:tgen_pkg::QUO_W]);
              numlo <= num[tgen_pkg::QUO_W-1:0];
              quo   <= '0;
              cnt   <= 5'd1;
            end
          end else begin
            rem   <= qbit ? trial - {1'b0, len} : trial;
            numlo <= numlo << 1;
            quo   <= qfin;
            if (cnt == 5'(tgen_pkg::QUO_W)) begin
              tan[kc] <= neg[kc] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
              cnt     <= '0;
              kc      <= kc + 2'd1;
              if (kc == 2'd2) state <= M_DONE;
            end else begin
              cnt <= cnt + 5'd1;
            end
          end
        end
        M_DONE: begin
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.busy = (state != M_IDLE);
    rsp.done = (state == M_DONE);
    rsp.deg  = deg;
    rsp.tx   = tan[0];
    rsp.ty   = tan[1];
    rsp.tz   = tan[2];
  end

endmodule
